@@ hw/rtl/ttb_pkg.sv @@
// Shared types and constants of the triangle tangent/bitangent block.
package ttb_pkg;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL0 = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SAT  = 7'b0100000,
    S_DONE = 7'b1000000
  } ttb_state_e;

  localparam logic [2:0] TGT_DET     = 3'd0;
  localparam logic [2:0] TGT_TAN_X   = 3'd1;
  localparam logic [2:0] TGT_TAN_Y   = 3'd2;
  localparam logic [2:0] TGT_TAN_Z   = 3'd3;
  localparam logic [2:0] TGT_BITAN_X = 3'd4;
  localparam logic [2:0] TGT_BITAN_Y = 3'd5;
  localparam logic [2:0] TGT_BITAN_Z = 3'd6;

  typedef struct packed {
    logic       store_corner;
    logic       corner_sel;
    logic       capture;
    logic       mul_en;
    logic       mul_phase;
    logic [2:0] target;
    logic       det_wr;
    logic       div_start;
    logic       div_step;
    logic       res_wr;
    logic       load_out;
    logic       degen;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } ttb_status_t;

endpackage

@@ hw/rtl/ttb_if.sv @@
// Corner and result channel interfaces.
interface ttb_in_if #(parameter int unsigned COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] tex_u;
  logic signed [COORD_WIDTH-1:0] tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_out_if #(parameter int unsigned COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] tan_x;
  logic signed [COORD_WIDTH-1:0] tan_y;
  logic signed [COORD_WIDTH-1:0] tan_z;
  logic signed [COORD_WIDTH-1:0] bitan_x;
  logic signed [COORD_WIDTH-1:0] bitan_y;
  logic signed [COORD_WIDTH-1:0] bitan_z;
  logic                          degenerate;
  modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  degenerate, input ready);
  modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  degenerate, output ready);
endinterface

@@ hw/rtl/ttb_ctrl.sv @@
// Sequencing state machine of the tangent/bitangent block.
module ttb_ctrl
  import ttb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ttb_status_t status_i,
  output ttb_cmd_t    cmd_o
);

  ttb_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] tgt_q, tgt_d;
  logic       degen_q, degen_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.target = tgt_q;
    cmd_o.degen = degen_q;
    state_d     = state_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    degen_d     = degen_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q < 2'd2) begin
            cmd_o.store_corner = 1'b1;
            cmd_o.corner_sel   = cnt_q[0];
            cnt_d              = cnt_q + 2'd1;
          end else begin
            cmd_o.capture = 1'b1;
            cnt_d         = '0;
            tgt_d         = TGT_DET;
            state_d       = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_phase = 1'b1;
        state_d         = S_CHK;
      end
      S_CHK: begin
        if (tgt_q == TGT_DET) begin
          cmd_o.det_wr = 1'b1;
          if (status_i.det_zero) begin
            degen_d = 1'b1;
            state_d = S_DONE;
          end else begin
            degen_d = 1'b0;
            tgt_d   = TGT_TAN_X;
            state_d = S_MUL0;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        cmd_o.res_wr = 1'b1;
        if (tgt_q == TGT_BITAN_Z) begin
          state_d = S_DONE;
        end else begin
          tgt_d   = tgt_q + 3'd1;
          state_d = S_MUL0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tgt_q       <= TGT_DET;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tgt_q       <= tgt_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/ttb_dp.sv @@
// Datapath: corner store, shared multiplier, serial divider, result registers.
module ttb_dp
  import ttb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttb_cmd_t                      cmd_i,
  output ttb_status_t                   status_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] tex_u_i,
  input  logic signed [COORD_WIDTH-1:0] tex_v_i,
  output logic signed [COORD_WIDTH-1:0] vec_o [6],
  output logic                          degenerate_o
);

  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned NUM_W = PW + 1;
  localparam int unsigned QW    = NUM_W + FRAC_BITS;
  localparam int unsigned REM_W = NUM_W + 1;
  localparam int unsigned CNT_W = $clog2(QW);

  logic signed [COORD_WIDTH-1:0] p0_q [3];
  logic signed [COORD_WIDTH-1:0] p1_q [3];
  logic signed [COORD_WIDTH-1:0] u0_q, v0_q, u1_q, v1_q;
  logic signed [DW-1:0]          dp1_q [3];
  logic signed [DW-1:0]          dp2_q [3];
  logic signed [DW-1:0]          du1_q, dv1_q, du2_q, dv2_q;
  logic signed [COORD_WIDTH-1:0] in_pos [3];

  logic signed [NUM_W-1:0] acc_q, det_q;
  logic signed [DW-1:0]    ma, mb;
  logic signed [PW-1:0]    prod;
  logic signed [NUM_W-1:0] prod_ext;
  logic [1:0]              k;

  logic [QW-1:0]      dvd_q, quo_q;
  logic [REM_W-1:0]   rem_q, rem_sh;
  logic [NUM_W-1:0]   den_q, num_mag, den_mag;
  logic               neg_q, ge;
  logic [CNT_W-1:0]   cnt_q;
  logic [QW-1:0]      lim, sat, sval;
  logic [2:0]         ridx;

  logic signed [COORD_WIDTH-1:0] res_q [6];
  logic signed [COORD_WIDTH-1:0] out_q [6];
  logic                          degen_q;

  assign in_pos[0] = pos_x_i;
  assign in_pos[1] = pos_y_i;
  assign in_pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_corner) begin
      if (cmd_i.corner_sel) begin
        for (int i = 0; i < 3; i++) p1_q[i] <= in_pos[i];
        u1_q <= tex_u_i;
        v1_q <= tex_v_i;
      end else begin
        for (int i = 0; i < 3; i++) p0_q[i] <= in_pos[i];
        u0_q <= tex_u_i;
        v0_q <= tex_v_i;
      end
    end
    if (cmd_i.capture) begin
      for (int i = 0; i < 3; i++) begin
        dp1_q[i] <= {p1_q[i][COORD_WIDTH-1], p1_q[i]} - {p0_q[i][COORD_WIDTH-1], p0_q[i]};
        dp2_q[i] <= {in_pos[i][COORD_WIDTH-1], in_pos[i]} - {p0_q[i][COORD_WIDTH-1], p0_q[i]};
      end
      du1_q <= {u1_q[COORD_WIDTH-1], u1_q} - {u0_q[COORD_WIDTH-1], u0_q};
      dv1_q <= {v1_q[COORD_WIDTH-1], v1_q} - {v0_q[COORD_WIDTH-1], v0_q};
      du2_q <= {tex_u_i[COORD_WIDTH-1], tex_u_i} - {u0_q[COORD_WIDTH-1], u0_q};
      dv2_q <= {tex_v_i[COORD_WIDTH-1], tex_v_i} - {v0_q[COORD_WIDTH-1], v0_q};
    end
  end

  always_comb begin
    k  = '0;
    ma = '0;
    mb = '0;
    case (cmd_i.target)
      TGT_DET: begin
        ma = cmd_i.mul_phase ? dv1_q : du1_q;
        mb = cmd_i.mul_phase ? du2_q : dv2_q;
      end
      TGT_TAN_X, TGT_TAN_Y, TGT_TAN_Z: begin
        k  = 2'(cmd_i.target - TGT_TAN_X);
        ma = cmd_i.mul_phase ? dp2_q[k] : dp1_q[k];
        mb = cmd_i.mul_phase ? dv1_q : dv2_q;
      end
      TGT_BITAN_X, TGT_BITAN_Y, TGT_BITAN_Z: begin
        k  = 2'(cmd_i.target - TGT_BITAN_X);
        ma = cmd_i.mul_phase ? dp1_q[k] : dp2_q[k];
        mb = cmd_i.mul_phase ? du2_q : du1_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = {prod[PW-1], prod};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      acc_q <= cmd_i.mul_phase ? (acc_q - prod_ext) : prod_ext;
    end
    if (cmd_i.det_wr) begin
      det_q <= acc_q;
    end
  end

  assign num_mag = acc_q[NUM_W-1] ? NUM_W'(-acc_q) : NUM_W'(acc_q);
  assign den_mag = det_q[NUM_W-1] ? NUM_W'(-det_q) : NUM_W'(det_q);
  assign rem_sh  = {rem_q[REM_W-2:0], dvd_q[QW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
      den_q <= den_mag;
      neg_q <= acc_q[NUM_W-1] ^ det_q[NUM_W-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign lim  = neg_q ? {{(QW-COORD_WIDTH){1'b0}}, 1'b1, {(COORD_WIDTH-1){1'b0}}}
                      : {{(QW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  assign sat  = (quo_q > lim) ? lim : quo_q;
  assign sval = neg_q ? (~sat + 1'b1) : sat;
  assign ridx = cmd_i.target - 3'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_wr) begin
      res_q[ridx] <= sval[COORD_WIDTH-1:0];
    end
    if (cmd_i.load_out) begin
      for (int i = 0; i < 6; i++) out_q[i] <= cmd_i.degen ? '0 : res_q[i];
      degen_q <= cmd_i.degen;
    end
  end

  assign status_o.det_zero = (acc_q == '0);
  assign status_o.div_done = (cnt_q == CNT_W'(QW - 1));
  assign vec_o             = out_q;
  assign degenerate_o      = degen_q;

endmodule

@@ hw/rtl/triangle_tangent_bitangent.sv @@
// Top level of the triangle tangent/bitangent unit.
// Usage:
//   corner_i takes one triangle corner per word: position x,y,z and texture
//   u,v, all signed fixed point with FRAC_BITS fraction bits. The first two
//   corners are stored and give no result; the third completes the triangle.
//   result_o carries one word per triangle: tangent, bitangent and a
//   degenerate flag (vectors zero when the UV determinant is zero).
//   The third corner starts the computation of the determinant and the six
//   components; a degenerate triangle skips the components. The work is
//   done by the restoring divider, one quotient bit per cycle, shared by
//   the six components, and by one shared multiplier used twice per
//   component.
//   corner_i is not ready while a triangle is being computed.
//   A finished result waits in the output register; a stall on result_o
//   only holds the next triangle once its own result is ready to load.
//   Reset clears the corner count and drops any pending result.
module triangle_tangent_bitangent
  import ttb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttb_in_if.sink     corner_i,
  ttb_out_if.source  result_o
);

  ttb_cmd_t                      cmd;
  ttb_status_t                   status;
  logic signed [COORD_WIDTH-1:0] vec [6];

  ttb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corner_i.valid),
    .in_ready_o  (corner_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttb_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .pos_x_i      (corner_i.pos_x),
    .pos_y_i      (corner_i.pos_y),
    .pos_z_i      (corner_i.pos_z),
    .tex_u_i      (corner_i.tex_u),
    .tex_v_i      (corner_i.tex_v),
    .vec_o        (vec),
    .degenerate_o (result_o.degenerate)
  );

  assign result_o.tan_x   = vec[0];
  assign result_o.tan_y   = vec[1];
  assign result_o.tan_z   = vec[2];
  assign result_o.bitan_x = vec[3];
  assign result_o.bitan_y = vec[4];
  assign result_o.bitan_z = vec[5];

endmodule

@@ hw/rtl/ttb_checker.sv @@
// Port-level checks of the tangent/bitangent unit and their binding.
module ttb_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   degenerate_i,
  input logic [COORD_WIDTH-1:0] tan_x_i,
  input logic [COORD_WIDTH-1:0] tan_y_i,
  input logic [COORD_WIDTH-1:0] tan_z_i,
  input logic [COORD_WIDTH-1:0] bitan_x_i,
  input logic [COORD_WIDTH-1:0] bitan_y_i,
  input logic [COORD_WIDTH-1:0] bitan_z_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tan_x_i) && $stable(bitan_z_i)
      && $stable(degenerate_i))
    else $error("result word changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> tan_x_i == '0 && tan_y_i == '0 && tan_z_i == '0
      && bitan_x_i == '0 && bitan_y_i == '0 && bitan_z_i == '0)
    else $error("degenerate result with nonzero vector");

  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a busy cycle");

endmodule

bind triangle_tangent_bitangent ttb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ttb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (corner_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .degenerate_i (result_o.degenerate),
  .tan_x_i      (result_o.tan_x),
  .tan_y_i      (result_o.tan_y),
  .tan_z_i      (result_o.tan_z),
  .bitan_x_i    (result_o.bitan_x),
  .bitan_y_i    (result_o.bitan_y),
  .bitan_z_i    (result_o.bitan_z)
);

@@ dv/tb.sv @@
// Testbench for the triangle tangent/bitangent unit: corner stream in, checked result stream out.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam logic signed [CW-1:0] QMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] QMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] p[3];
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
  } corner_t;

  typedef struct {
    logic signed [CW-1:0] vec[6];
    logic                 degen;
  } frame_t;

  logic clk_i;
  logic rst_ni;

  ttb_in_if  #(.COORD_WIDTH(CW)) cin ();
  ttb_out_if #(.COORD_WIDTH(CW)) cout ();

  triangle_tangent_bitangent #(.COORD_WIDTH(CW), .FRAC_BITS(16)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .corner_i (cin),
    .result_o (cout)
  );

  corner_t corner_q[$];
  frame_t  frame_q[$];
  corner_t held_corner[2];
  int      held_cnt;
  int      sent_cnt;
  int      frame_cnt;
  int      err_cnt;
  int      send_gap;
  int      recv_gap;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void queue_corner(corner_t c);
    corner_q.insert(corner_q.size(), c);
  endfunction

  function automatic logic signed [CW-1:0] scaled_div(wide_t num, wide_t den);
    wide_t q;
    q = (num <<< 16) / den;
    if (q > wide_t'(QMAX)) return QMAX;
    if (q < wide_t'(QMIN)) return QMIN;
    return q[CW-1:0];
  endfunction

  function automatic logic frame_from_corner(corner_t c, output frame_t f);
    wide_t dp1[3];
    wide_t dp2[3];
    wide_t du1, dv1, du2, dv2, det;
    f.degen = 1'b0;
    foreach (f.vec[k]) f.vec[k] = '0;
    if (held_cnt < 2) begin
      held_corner[held_cnt] = c;
      held_cnt++;
      return 1'b0;
    end
    held_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = wide_t'(held_corner[1].p[k]) - wide_t'(held_corner[0].p[k]);
      dp2[k] = wide_t'(c.p[k]) - wide_t'(held_corner[0].p[k]);
    end
    du1 = wide_t'(held_corner[1].u) - wide_t'(held_corner[0].u);
    dv1 = wide_t'(held_corner[1].v) - wide_t'(held_corner[0].v);
    du2 = wide_t'(c.u) - wide_t'(held_corner[0].u);
    dv2 = wide_t'(c.v) - wide_t'(held_corner[0].v);
    det = du1 * dv2 - dv1 * du2;
    if (det == 0) begin
      f.degen = 1'b1;
      return 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      f.vec[k]     = scaled_div(dp1[k] * dv2 - dp2[k] * dv1, det);
      f.vec[3 + k] = scaled_div(dp2[k] * du1 - dp1[k] * du2, det);
    end
    return 1'b1;
  endfunction

  function automatic corner_t mk(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                 logic signed [CW-1:0] z, logic signed [CW-1:0] u,
                                 logic signed [CW-1:0] v);
    corner_t c;
    c.p[0] = x;
    c.p[1] = y;
    c.p[2] = z;
    c.u    = u;
    c.v    = v;
    return c;
  endfunction

  function automatic logic signed [CW-1:0] near_zero();
    return CW'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic corner_t any_corner();
    return mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  function automatic corner_t mild_corner();
    return mk(near_zero(), near_zero(), near_zero(), near_zero(), near_zero());
  endfunction

  function automatic int draw_gap();
    if ((sent_cnt / 150) % 3 == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t f;
    if (!rst_ni) begin
      cin.valid <= 1'b0;
      cin.pos_x <= '0;
      cin.pos_y <= '0;
      cin.pos_z <= '0;
      cin.tex_u <= '0;
      cin.tex_v <= '0;
      send_gap  <= 0;
      held_cnt  = 0;
      sent_cnt  = 0;
    end else if (!cin.valid || cin.ready) begin
      if (cin.valid) begin
        if (frame_from_corner(mk(cin.pos_x, cin.pos_y, cin.pos_z, cin.tex_u, cin.tex_v), f))
          frame_q.insert(frame_q.size(), f);
        sent_cnt++;
      end
      if (send_gap > 0) begin
        cin.valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (corner_q.size() > 0) begin
        corner_t c;
        c = corner_q.pop_front();
        cin.pos_x <= c.p[0];
        cin.pos_y <= c.p[1];
        cin.pos_z <= c.p[2];
        cin.tex_u <= c.u;
        cin.tex_v <= c.v;
        cin.valid <= 1'b1;
        send_gap  <= draw_gap();
      end else begin
        cin.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t got, want;
    if (!rst_ni) begin
      cout.ready <= 1'b0;
      recv_gap   <= 0;
      frame_cnt  = 0;
      err_cnt    = 0;
    end else begin
      if (cout.valid && cout.ready) begin
        got.vec[0] = cout.tan_x;
        got.vec[1] = cout.tan_y;
        got.vec[2] = cout.tan_z;
        got.vec[3] = cout.bitan_x;
        got.vec[4] = cout.bitan_y;
        got.vec[5] = cout.bitan_z;
        got.degen  = cout.degenerate;
        if (frame_q.size() == 0) begin
          $display("%t unexpected result word", $realtime);
          err_cnt++;
        end else begin
          want = frame_q.pop_front();
          foreach (want.vec[k])
            if (got.vec[k] !== want.vec[k]) begin
              $display("%t field %0d: expected %h actual %h", $realtime, k,
                       want.vec[k], got.vec[k]);
              err_cnt++;
            end
          if (got.degen !== want.degen) begin
            $display("%t degenerate: expected %b actual %b", $realtime, want.degen,
                     got.degen);
            err_cnt++;
          end
        end
        frame_cnt++;
      end
      if (cout.valid && cout.ready) begin
        cout.ready <= 1'b0;
        if (frame_cnt == 40) recv_gap <= 3000;
        else if ((frame_cnt / 60) % 3 == 0) recv_gap <= 0;
        else recv_gap <= $urandom_range(0, 13);
      end else if (recv_gap > 0) begin
        cout.ready <= 1'b0;
        recv_gap   <= recv_gap - 1;
      end else begin
        cout.ready <= 1'b1;
      end
    end
  end

  initial begin
    corner_t a, b;
    int      kind;
    rst_ni = 1'b0;
    // unit triangle
    queue_corner(mk(0, 0, 0, 0, 0));
    queue_corner(mk(ONE, 0, 0, ONE, 0));
    queue_corner(mk(0, ONE, 0, 0, ONE));
    // repeated uv gives zero determinant
    queue_corner(mk(ONE, 2 * ONE, 3 * ONE, ONE, ONE));
    queue_corner(mk(QMAX, QMIN, 0, ONE, ONE));
    queue_corner(mk(-ONE, QMAX, QMIN, ONE, ONE));
    // all-zero triangle
    queue_corner(mk(0, 0, 0, 0, 0));
    queue_corner(mk(0, 0, 0, 0, 0));
    queue_corner(mk(0, 0, 0, 0, 0));
    // widest spans
    queue_corner(mk(QMIN, QMIN, QMIN, QMIN, QMIN));
    queue_corner(mk(QMAX, QMAX, QMAX, QMAX, QMIN));
    queue_corner(mk(QMIN, QMAX, QMIN, QMIN, QMAX));
    // tiny determinant, saturate both ways
    queue_corner(mk(0, 0, 0, 0, 0));
    queue_corner(mk(QMAX, QMIN, QMAX, 1, 0));
    queue_corner(mk(QMIN, QMAX, 1, 0, 1));
    // negative determinant
    queue_corner(mk(0, 0, 0, 0, 0));
    queue_corner(mk(ONE, 0, -ONE, 0, ONE));
    queue_corner(mk(0, ONE, ONE, ONE, 0));
    // all ones bits
    queue_corner(mk(-1, -1, -1, -1, -1));
    queue_corner(mk(0, -1, 0, 0, -1));
    queue_corner(mk(-1, 0, -1, -1, 0));
    for (int t = 0; t < 600; t++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        repeat (3) queue_corner(any_corner());
      end else if (kind <= 6) begin
        repeat (3) queue_corner(mild_corner());
      end else if (kind == 7) begin
        a = mild_corner();
        b = mild_corner();
        queue_corner(a);
        queue_corner(b);
        b.p[0] = near_zero();
        b.u    = b.u + (b.u - a.u);
        b.v    = b.v + (b.v - a.v);
        queue_corner(b);
      end else if (kind == 8) begin
        a = any_corner();
        queue_corner(a);
        b = any_corner();
        b.u = a.u + CW'($urandom_range(1, 3));
        b.v = a.v;
        queue_corner(b);
        b = any_corner();
        b.u = a.u;
        b.v = a.v - CW'($urandom_range(1, 3));
        queue_corner(b);
      end else begin
        queue_corner(any_corner());
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (corner_q.size() == 0 && !cin.valid);
    wait (frame_q.size() == 0);
    repeat (600) @(posedge clk_i);
    if (err_cnt == 0 && frame_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
